>>> rtl/core/bdph_pkg.sv
// Shared constants and types for the byte dot-product modular hash.
package bdph_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int HASH_BITS       = 16;
   localparam int MOD_BITS        = 17;
   localparam int KEYLEN_BITS     = 5;
   localparam int FIELD_BITS      = 16;
   localparam int FIELDS_PER_WORD = 4;
   localparam int COEFF_WORDS     = 4;
   localparam int CSR_DATA_BITS   = FIELD_BITS * FIELDS_PER_WORD;
   localparam int CSR_INDEX_BITS  = 3;

   localparam int MAX_KEY_BYTES_DEFAULT = 16;
   localparam int COEFF_BITS_DEFAULT    = 16;

   localparam logic [MOD_BITS-1:0]    MOD_FULL         = 17'h10000;
   localparam logic [KEYLEN_BITS-1:0] KEY_LENGTH_RESET = 5'd13;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEFF_0    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEFF_1    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEFF_2    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEFF_3    = 3'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

>>> rtl/core/bdph_mul.sv
// Bit-serial shift-add multiplier: key byte times coefficient, MSB first.
module bdph_mul #(
   parameter int CW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [CW-1:0]                  coeff,
   input  logic [bdph_pkg::BYTE_BITS-1:0] byte_in,
   output bdph_pkg::unit_status_type      status,
   output logic [CW+bdph_pkg::BYTE_BITS-1:0] product
);
   import bdph_pkg::*;

   localparam int PW    = CW + BYTE_BITS;
   localparam int CNT_W = $clog2(BYTE_BITS);

   logic [BYTE_BITS-1:0] bits_ff;
   logic [CW-1:0]        coeff_ff;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff, done_ff;

   assign acc_in = {acc_ff[PW-2:0], 1'b0} + (bits_ff[BYTE_BITS-1] ? PW'(coeff_ff) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(BYTE_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bits_ff  <= byte_in;
         coeff_ff <= coeff;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         bits_ff <= {bits_ff[BYTE_BITS-2:0], 1'b0};
         acc_ff  <= acc_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

>>> rtl/core/bdph_mod.sv
// Restoring remainder unit: one dividend bit per cycle against the modulus.
module bdph_mod #(
   parameter int SW = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [SW-1:0]                 dividend,
   input  logic [bdph_pkg::MOD_BITS-1:0] modulus,
   output bdph_pkg::unit_status_type     status,
   output logic [bdph_pkg::HASH_BITS-1:0] remainder
);
   import bdph_pkg::*;

   localparam int CNT_W = $clog2(SW);

   logic [SW-1:0]       div_ff;
   logic [MOD_BITS-1:0] mod_ff;
   logic [MOD_BITS-1:0] rem_ff, rem_in;
   logic [MOD_BITS:0]   trial;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff, done_ff;

   // remainder stays below the modulus, so one subtract per bit suffices
   always_comb begin
      trial = {rem_ff, div_ff[SW-1]};
      if (trial >= {1'b0, mod_ff}) begin
         rem_in = MOD_BITS'(trial - {1'b0, mod_ff});
      end else begin
         rem_in = trial[MOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= dividend;
         mod_ff <= modulus;
         rem_ff <= '0;
      end else if (busy_ff) begin
         div_ff <= {div_ff[SW-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff[HASH_BITS-1:0];

endmodule

>>> rtl/core/byte_dot_product_mod_hash_top.sv
// Top level: csr registers, key sequencing and result register of the byte hash.
// An item runs through BYTE_BITS serial multiply steps (8 at default widths), then SW
// serial remainder steps (SW = 25 at default widths), in states ST_MUL, ST_MOD, ST_FINISH.
// rsp_valid is registered from ST_FINISH of a key's last byte once the result slot is free.
// Only one item is in work at a time; a waiting result holds back only a last byte.
// Synchronous reset restores the register defaults, position 0 and running value 0.
module byte_dot_product_mod_hash_top #(
   parameter int MAX_KEY_BYTES = bdph_pkg::MAX_KEY_BYTES_DEFAULT,
   parameter int COEFF_BITS    = bdph_pkg::COEFF_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bdph_pkg::BYTE_BITS-1:0]      req_key_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bdph_pkg::HASH_BITS-1:0]      rsp_hash_value,
   input  logic                                csr_wr_en,
   input  logic [bdph_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdph_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import bdph_pkg::*;

   localparam int CW    = (COEFF_BITS < FIELD_BITS) ? COEFF_BITS : FIELD_BITS;
   localparam int PW    = CW + BYTE_BITS;
   localparam int SW    = ((PW > HASH_BITS) ? PW : HASH_BITS) + 1;
   localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LCLOG = $clog2(MAX_KEY_BYTES + 1);
   localparam int LEN_W = ((LCLOG > KEYLEN_BITS) ? LCLOG : KEYLEN_BITS) + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_MOD, ST_FINISH} state_type;

   state_type state_ff, state_in;

   logic [MOD_BITS-1:0]      modulus_ff;
   logic [KEYLEN_BITS-1:0]   key_length_ff;
   logic [CSR_DATA_BITS-1:0] coeff_ff [COEFF_WORDS];

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [HASH_BITS-1:0] running_ff, running_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HASH_BITS-1:0] rsp_hash_ff, rsp_hash_in;

   logic [LEN_W-1:0]         pos_wide, eff_len, len_wide;
   logic [FIELD_BITS-1:0]    field;
   logic [CSR_DATA_BITS-1:0] word;
   logic [CW-1:0]            coeff_sel;
   logic [MOD_BITS-1:0]      eff_mod;
   logic                     accept, is_last;

   unit_status_type      mul_st, mod_st;
   logic [PW-1:0]        product;
   logic [HASH_BITS-1:0] remainder;
   logic [SW-1:0]        dividend;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= MOD_FULL;
         key_length_ff <= KEY_LENGTH_RESET;
         for (int i = 0; i < COEFF_WORDS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODULUS:    modulus_ff    <= csr_wr_data[MOD_BITS-1:0];
            CSR_KEY_LENGTH: key_length_ff <= csr_wr_data[KEYLEN_BITS-1:0];
            CSR_COEFF_0:    coeff_ff[0]   <= csr_wr_data;
            CSR_COEFF_1:    coeff_ff[1]   <= csr_wr_data;
            CSR_COEFF_2:    coeff_ff[2]   <= csr_wr_data;
            CSR_COEFF_3:    coeff_ff[3]   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // effective modulus and key length
   always_comb begin
      if (modulus_ff == '0 || modulus_ff > MOD_FULL) begin
         eff_mod = MOD_FULL;
      end else begin
         eff_mod = modulus_ff;
      end
      len_wide = LEN_W'(key_length_ff);
      if (len_wide == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_wide > LEN_W'(MAX_KEY_BYTES)) begin
         eff_len = LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = len_wide;
      end
   end

   // coefficient for the current position; positions past the last field use zero
   always_comb begin
      pos_wide = LEN_W'(pos_ff);
      word     = coeff_ff[pos_wide[3:2]];
      if (pos_wide < LEN_W'(COEFF_WORDS * FIELDS_PER_WORD)) begin
         field = word[pos_wide[1:0]*FIELD_BITS +: FIELD_BITS];
      end else begin
         field = '0;
      end
      coeff_sel = field[CW-1:0];
   end

   assign accept   = req_valid && req_ready;
   assign is_last  = (pos_wide + LEN_W'(1)) >= eff_len;
   assign dividend = SW'(product) + SW'(running_ff);

   bdph_mul #(.CW(CW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .coeff   (coeff_sel),
      .byte_in (req_key_byte),
      .status  (mul_st),
      .product (product)
   );

   bdph_mod #(.SW(SW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_st.done),
      .dividend  (dividend),
      .modulus   (eff_mod),
      .status    (mod_st),
      .remainder (remainder)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_st.done) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (mod_st.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!is_last) begin
               running_in = remainder;
               pos_in     = pos_ff + 1'b1;
               state_in   = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // last byte of the key: hand out the hash once the slot is free
               rsp_valid_in = 1'b1;
               rsp_hash_in  = remainder;
               running_in   = '0;
               pos_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hash_ff <= rsp_hash_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   a_mul_done_in_mul : assert property (@(posedge clock) disable iff (reset)
      mul_st.done |-> state_ff == ST_MUL)
      else $error("multiply finished outside the multiply phase");

   a_mod_done_in_mod : assert property (@(posedge clock) disable iff (reset)
      mod_st.done |-> state_ff == ST_MOD)
      else $error("remainder finished outside the reduction phase");

   a_units_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(mul_st.busy && mod_st.busy))
      else $error("multiplier and remainder unit busy together");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_hash_ff == $past(rsp_hash_ff)))
      else $error("waiting result overwritten");

endmodule
